FILE: rtl/core/bsmm_pkg.sv
`default_nettype none

package bsmm_pkg;

  // Storage depth default
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // Field widths
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 7;
  localparam int unsigned ActW = 2;
  localparam int unsigned StW  = 2;

  typedef enum logic [ActW-1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;     // insert new_key this cycle
    logic scan_load;  // load each cell's gap into its min register
    logic scan_step;  // fold right neighbor's min into own
  } chain_ctl_t;

  // Flip the sign bit so unsigned order matches signed order
  function automatic logic [ValW-1:0] to_key(input logic [ValW-1:0] v);
    to_key = v ^ {1'b1, {(ValW-1){1'b0}}};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bounded_set_min_max_gap_core.sv
// Channel   Signals                                        Dir  Beat taken when
// command   start, busy, action_i, value_i                 in   start && !busy
// config    cfg_valid_i, cfg_ready_o, cfg_data_i           in   cfg_valid_i && cfg_ready_o
// result    done_o, status_o, shortest_span_o,             out  done_o (one cycle)
//           longest_span_o
//
// Add, clear and no-op: result in the next cycle, busy stays low.
// Query with n >= 2 stored values: busy while the minimum gap ripples one
// cell per cycle down the cell chain, result in the next cycle.
// Query with fewer than two values answers in the next cycle.
// Reset clears the count, capacity and control; cell contents need none.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module bounded_set_min_max_gap_core #(
  parameter int unsigned MaxEntries = bsmm_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [bsmm_pkg::ActW-1:0]   action_i,
  input  wire logic signed [bsmm_pkg::ValW-1:0] value_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bsmm_pkg::CapW-1:0]   cfg_data_i,
  output logic                             done_o,
  output logic      [bsmm_pkg::StW-1:0]    status_o,
  output logic      [bsmm_pkg::ValW-1:0]   shortest_span_o,
  output logic      [bsmm_pkg::ValW-1:0]   longest_span_o
);
  import bsmm_pkg::*;

  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MaxEntries);

  state_e            state_q, state_d;
  logic [CapW-1:0]   cap_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   steps_q, steps_d;
  logic [ValW-1:0]   hi_q, hi_d;
  logic              accept;
  action_e           act;
  logic [ValW-1:0]   new_key;
  logic [CmpW-1:0]   limit;
  logic              full;
  chain_ctl_t        ctl;

  logic              res_vld_d;
  logic [StW-1:0]    res_st_d;
  logic [ValW-1:0]   res_short_d, res_long_d;
  logic              done_q;
  logic [StW-1:0]    status_q;
  logic [ValW-1:0]   short_q, long_q;

  logic [ValW-1:0]   keys  [MaxEntries];
  logic [ValW-1:0]   mins  [MaxEntries];
  logic              gts   [MaxEntries];

  assign accept  = start && !busy;
  assign act     = action_e'(action_i);
  assign new_key = to_key(value_i);
  assign busy    = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Effective capacity
  always_comb begin
    limit = (CmpW'(cap_q) < MaxCmp) ? CmpW'(cap_q) : MaxCmp;
  end
  assign full = (CmpW'(count_q) >= limit);

  // Cell chain
  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    logic [ValW-1:0] lkey;
    logic            lgt;
    logic [ValW-1:0] rmin;
    if (i == 0) begin : g_head
      assign lkey = '0;
      assign lgt  = 1'b0;
    end else begin : g_body
      assign lkey = keys[i-1];
      assign lgt  = gts[i-1];
    end
    if (i == MaxEntries - 1) begin : g_tail
      assign rmin = '1;
    end else begin : g_mid
      assign rmin = mins[i+1];
    end
    bsmm_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .new_key_i   (new_key),
      .left_key_i  (lkey),
      .left_gt_i   (lgt),
      .right_min_i (rmin),
      .key_o       (keys[i]),
      .gt_o        (gts[i]),
      .min_o       (mins[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && act == ACT_QUERY && count_q >= CntW'(2)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (steps_q == '0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and result
  always_comb begin
    ctl         = '0;
    count_d     = count_q;
    steps_d     = steps_q;
    hi_d        = hi_q;
    res_vld_d   = 1'b0;
    res_st_d    = ST_OK;
    res_short_d = '0;
    res_long_d  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (act)
            ACT_ADD: begin
              res_vld_d = 1'b1;
              if (full) begin
                res_st_d = ST_FULL;
              end else begin
                ctl.ins_en = 1'b1;
                count_d    = count_q + CntW'(1);
                if (count_q == '0 || new_key > hi_q) begin
                  hi_d = new_key;
                end
              end
            end
            ACT_CLEAR: begin
              res_vld_d = 1'b1;
              count_d   = '0;
            end
            ACT_QUERY: begin
              if (count_q < CntW'(2)) begin
                res_vld_d = 1'b1;
                res_st_d  = ST_FEW;
              end else begin
                ctl.scan_load = 1'b1;
                steps_d       = count_q - CntW'(1);
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (steps_q != '0) begin
          ctl.scan_step = 1'b1;
          steps_d       = steps_q - CntW'(1);
        end else begin
          res_vld_d   = 1'b1;
          res_short_d = mins[0];
          res_long_d  = hi_q - keys[0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= '0;
      count_q <= '0;
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      steps_q <= steps_d;
      done_q  <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Result payload and running maximum
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    if (res_vld_d) begin
      status_q <= res_st_d;
      short_q  <= res_short_d;
      long_q   <= res_long_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign shortest_span_o = short_q;
  assign longest_span_o  = long_q;

endmodule

`default_nettype wire

FILE: rtl/core/bsmm_cell.sv
`default_nettype none

module bsmm_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  wire logic                      clk_i,
  input  wire bsmm_pkg::chain_ctl_t      ctl_i,
  input  wire logic [CntW-1:0]           count_i,
  input  wire logic [bsmm_pkg::ValW-1:0] new_key_i,
  input  wire logic [bsmm_pkg::ValW-1:0] left_key_i,
  input  wire logic                      left_gt_i,
  input  wire logic [bsmm_pkg::ValW-1:0] right_min_i,
  output logic      [bsmm_pkg::ValW-1:0] key_o,
  output logic                           gt_o,
  output logic      [bsmm_pkg::ValW-1:0] min_o
);
  import bsmm_pkg::*;

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic [ValW-1:0] key_q, key_d;
  logic [ValW-1:0] min_q, min_d;
  logic            occ;
  logic            at_end;
  logic [ValW-1:0] gap;

  assign occ    = (MyIdx < count_i);
  assign at_end = (MyIdx == count_i);
  assign gt_o   = occ && (key_q > new_key_i);

  // Gap to left neighbor; empty slots and the head give all ones
  always_comb begin
    if (Idx == 0 || !occ) begin
      gap = '1;
    end else begin
      gap = key_q - left_key_i;
    end
  end

  // Sorted insert: larger keys move one cell right, new key drops in the hole
  always_comb begin
    key_d = key_q;
    if (ctl_i.ins_en) begin
      if (left_gt_i) begin
        key_d = left_key_i;
      end else if (gt_o || at_end) begin
        key_d = new_key_i;
      end
    end
  end

  // Running minimum flows toward the head
  always_comb begin
    min_d = min_q;
    if (ctl_i.scan_load) begin
      min_d = gap;
    end else if (ctl_i.scan_step) begin
      min_d = (right_min_i < min_q) ? right_min_i : min_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    min_q <= min_d;
  end

  assign key_o = key_q;
  assign min_o = min_q;

endmodule

`default_nettype wire

FILE: rtl/core/bsmm_checker.sv
`default_nettype none

module bsmm_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [bsmm_pkg::ActW-1:0] action_i,
  input wire logic                      done_o,
  input wire logic [bsmm_pkg::StW-1:0]  status_o,
  input wire logic [bsmm_pkg::ValW-1:0] shortest_span_o,
  input wire logic [bsmm_pkg::ValW-1:0] longest_span_o
);
  import bsmm_pkg::*;

  // Non-query commands answer in the next cycle
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && action_i != ACT_QUERY |=> done_o)
    else $error("non-query command gave no result next cycle");

  // A result never appears while a scan is still running
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Refused adds and short queries report zero spans
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> shortest_span_o == '0 && longest_span_o == '0)
    else $error("error status with nonzero spans");

  // Smallest gap never exceeds the full spread
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> shortest_span_o <= longest_span_o)
    else $error("shortest span above longest span");

endmodule

bind bounded_set_min_max_gap_core bsmm_checker u_bsmm_checker (.*);

`default_nettype wire

FILE: tb/bounded_set_min_max_gap_core_tb.sv
module bounded_set_min_max_gap_core_tb;
  import bsmm_pkg::*;

  // One response beat of the block
  typedef struct {
    status_e     status;
    logic [31:0] shortest;
    logic [31:0] longest;
  } span_result_t;

  typedef enum bit {
    ROW_CMD,
    ROW_CFG
  } row_kind_e;

  // Directed script row; cfg rows carry the capacity in arg
  typedef struct {
    row_kind_e   kind;
    action_e     act;
    logic [31:0] arg;
    bit          known;
    status_e     status;
    logic [31:0] shortest;
    logic [31:0] longest;
  } script_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [ActW-1:0]      action_i;
  logic signed [31:0]   value_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CapW-1:0]      cfg_data_i;
  logic                 done_o;
  logic [StW-1:0]       status_o;
  logic [31:0]          shortest_span_o;
  logic [31:0]          longest_span_o;

  // Mirror of the set: ascending values, count and capacity
  logic [31:0]          held_vals [MAX_ENTRIES_DEF];
  int unsigned          held_count;
  logic [CapW-1:0]      cap_now;

  span_result_t         pending_spans [$];
  span_result_t         no_typed;
  int unsigned          fail_count;
  int unsigned          cmd_count;
  int unsigned          gap_max;

  localparam int unsigned ScriptLen = 29;

  script_row_t script [ScriptLen] = '{
    // capacity 0 after reset: every add refused
    '{ROW_CMD, ACT_ADD,   32'd5,        1'b1, ST_FULL, 32'd0,        32'd0},
    '{ROW_CMD, ACT_QUERY, 32'd0,        1'b1, ST_FEW,  32'd0,        32'd0},
    '{ROW_CMD, ACT_NOP,   32'hFFFFFFFF, 1'b1, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_CLEAR, 32'd0,        1'b1, ST_OK,   32'd0,        32'd0},
    '{ROW_CFG, ACT_ADD,   32'd3,        1'b0, ST_OK,   32'd0,        32'd0},
    // extremes of the value range, then a duplicate
    '{ROW_CMD, ACT_ADD,   32'h7FFFFFFF, 1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_QUERY, 32'd0,        1'b1, ST_FEW,  32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'h80000000, 1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_QUERY, 32'd0,        1'b1, ST_OK,   32'hFFFFFFFF, 32'hFFFFFFFF},
    '{ROW_CMD, ACT_ADD,   32'h7FFFFFFF, 1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'd1,        1'b1, ST_FULL, 32'd0,        32'd0},
    '{ROW_CMD, ACT_QUERY, 32'd0,        1'b1, ST_OK,   32'd0,        32'hFFFFFFFF},
    // capacity dropped under the count: contents kept, adds refused
    '{ROW_CFG, ACT_ADD,   32'd1,        1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'd0,        1'b1, ST_FULL, 32'd0,        32'd0},
    '{ROW_CMD, ACT_QUERY, 32'd0,        1'b1, ST_OK,   32'd0,        32'hFFFFFFFF},
    '{ROW_CMD, ACT_CLEAR, 32'h12345678, 1'b1, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_QUERY, 32'd0,        1'b1, ST_FEW,  32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'hFFFFFFFF, 1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'hFFFFFFFF, 1'b1, ST_FULL, 32'd0,        32'd0},
    // capacity above storage
    '{ROW_CFG, ACT_ADD,   32'd127,      1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_CLEAR, 32'd0,        1'b1, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'd0,        1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'hFFFFFFFB, 1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'd100,      1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_ADD,   32'hFFFFFFFB, 1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_QUERY, 32'd0,        1'b0, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_NOP,   32'd0,        1'b1, ST_OK,   32'd0,        32'd0},
    '{ROW_CMD, ACT_CLEAR, 32'd0,        1'b1, ST_OK,   32'd0,        32'd0},
    '{ROW_CFG, ACT_ADD,   32'd0,        1'b0, ST_OK,   32'd0,        32'd0}
  };

  bounded_set_min_max_gap_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .value_i         (value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .shortest_span_o (shortest_span_o),
    .longest_span_o  (longest_span_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Apply one command to the mirror and return the spans it yields
  function automatic span_result_t track_set(action_e act, logic [31:0] v);
    span_result_t res;
    int unsigned  lim;
    int unsigned  pos;
    int unsigned  i;
    logic [32:0]  gap;
    res.status   = ST_OK;
    res.shortest = '0;
    res.longest  = '0;
    case (act)
      ACT_ADD: begin
        lim = (cap_now < MAX_ENTRIES_DEF) ? cap_now : MAX_ENTRIES_DEF;
        if (held_count >= lim) begin
          res.status = ST_FULL;
        end else begin
          pos = held_count;
          while (pos > 0 && $signed(held_vals[pos-1]) > $signed(v)) begin
            held_vals[pos] = held_vals[pos-1];
            pos--;
          end
          held_vals[pos] = v;
          held_count++;
        end
      end
      ACT_CLEAR: held_count = 0;
      ACT_QUERY: begin
        if (held_count < 2) begin
          res.status = ST_FEW;
        end else begin
          // 33-bit differences, sign-extended, never overflow
          gap = {held_vals[held_count-1][31], held_vals[held_count-1]}
              - {held_vals[0][31], held_vals[0]};
          res.longest  = gap[31:0];
          res.shortest = '1;
          for (i = 1; i < held_count; i++) begin
            gap = {held_vals[i][31], held_vals[i]} - {held_vals[i-1][31], held_vals[i-1]};
            if (gap[31:0] < res.shortest) res.shortest = gap[31:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Values clustered around base, with some full-range and edge values
  function automatic logic [31:0] pick_value(logic [31:0] base, int unsigned spread);
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h00000000;
          default: return 32'hFFFFFFFF;
        endcase
      end
      default: return base + $urandom_range(0, spread);
    endcase
  endfunction

  // Entered at a falling edge; leaves at the falling edge after the beat
  task automatic send_cmd(action_e act, logic [31:0] v, bit known, span_result_t typed);
    int unsigned  gap;
    span_result_t pred;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      start    = 1'b0;
      action_i = ActW'($urandom);
      value_i  = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start    = 1'b1;
    action_i = act;
    value_i  = v;
    do @(posedge clk_i); while (busy);
    pred = track_set(act, v);
    if (known) pred = typed;
    pending_spans = {pending_spans, pred};
    if (act != ACT_NOP) cmd_count++;
    @(negedge clk_i);
  endtask

  // Capacity write, only once the block has drained
  task automatic write_capacity(logic [CapW-1:0] c);
    start = 1'b0;
    while (pending_spans.size() != 0) @(negedge clk_i);
    repeat (2 + $urandom_range(0, 3)) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_now = c;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = CapW'($urandom);
  endtask

  // Result checker: every done beat must match the oldest expectation
  always @(posedge clk_i) begin
    span_result_t want;
    if (rst_ni && done_o) begin
      if (pending_spans.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d shortest %h longest %h",
                 $time, status_o, shortest_span_o, longest_span_o);
        fail_count++;
      end else begin
        want = pending_spans.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          fail_count++;
        end
        if (shortest_span_o !== want.shortest) begin
          $display("%0t: shortest_span expected %h got %h",
                   $time, want.shortest, shortest_span_o);
          fail_count++;
        end
        if (longest_span_o !== want.longest) begin
          $display("%0t: longest_span expected %h got %h",
                   $time, want.longest, longest_span_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned  len;
    int unsigned  spread;
    int unsigned  i;
    logic [31:0]  base;
    logic [CapW-1:0] cap_pick;
    action_e      act;
    span_result_t typed;

    fail_count   = 0;
    cmd_count    = 0;
    held_count   = 0;
    cap_now      = '0;
    gap_max      = 3;
    no_typed.status   = ST_OK;
    no_typed.shortest = '0;
    no_typed.longest  = '0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    action_i     = ACT_NOP;
    value_i      = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed script
    foreach (script[k]) begin
      if (script[k].kind == ROW_CFG) begin
        write_capacity(script[k].arg[CapW-1:0]);
      end else begin
        typed.status   = script[k].status;
        typed.shortest = script[k].shortest;
        typed.longest  = script[k].longest;
        send_cmd(script[k].act, script[k].arg, script[k].known, typed);
      end
    end

    // Random phases: new capacity, mostly a clear, then a run of adds, queries, clears and no-ops
    while (cmd_count < 700) begin
      case ($urandom_range(0, 7))
        0: cap_pick = 7'd0;
        1: cap_pick = 7'd1;
        2: cap_pick = 7'd2;
        3: cap_pick = 7'd64;
        4: cap_pick = 7'd65;
        5: cap_pick = 7'd127;
        default: cap_pick = CapW'($urandom_range(3, 40));
      endcase
      write_capacity(cap_pick);
      gap_max = $urandom_range(0, 1) ? 3 : 0;
      if ($urandom_range(0, 3) != 0) send_cmd(ACT_CLEAR, $urandom, 1'b0, no_typed);

      base = $urandom;
      case ($urandom_range(0, 4))
        0: spread = 0;
        1: spread = 3;
        2: spread = 255;
        3: spread = 65535;
        default: spread = 32'hFFFFFFFF;
      endcase
      len = (cap_pick >= 64 && $urandom_range(0, 1)) ? 72 : $urandom_range(2, 24);

      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 15))
          0: act = ACT_NOP;
          1: act = ACT_CLEAR;
          2, 3, 4: act = ACT_QUERY;
          default: act = ACT_ADD;
        endcase
        send_cmd(act, (act == ACT_ADD) ? pick_value(base, spread) : $urandom,
                 1'b0, no_typed);
      end
      send_cmd(ACT_QUERY, $urandom, 1'b0, no_typed);
    end

    // Drain and finish
    start = 1'b0;
    while (pending_spans.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
